// ===== hw/rtl/bmte_pkg.sv =====
// Package for the byte matrix transform engine: opcodes, sequencer states,
// the memory request struct and the address helper. No dependencies.
`default_nettype none
package bmte_pkg;
   localparam int DEF_MAX_SIDE = 64;

   typedef enum logic [3:0] {
      OP_SET_DIMS = 4'd0, OP_WRITE = 4'd1, OP_READ = 4'd2, OP_SWAP_CELL = 4'd3,
      OP_SWAP_ROW = 4'd4, OP_SWAP_COL = 4'd5, OP_SWAP_DIAG = 4'd6,
      OP_FLIP_ROW = 4'd7, OP_FLIP_COL = 4'd8, OP_FLIP_DIAG = 4'd9,
      OP_MIRROR_LR = 4'd10, OP_MIRROR_TB = 4'd11, OP_ROTATE = 4'd12,
      OP_TRANSPOSE = 4'd13, OP_BAD_14 = 4'd14, OP_BAD_15 = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD, ST_WAIT, ST_WR_A, ST_WR_B, ST_DONE
   } state_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic        wr_en;
      logic [12:0] wr_addr;
      logic [7:0]  wr_data;
      logic [12:0] rd_addr_a;
      logic [12:0] rd_addr_b;
   } mem_req_type;

   function automatic logic [12:0] cell_addr(input logic bank, input logic [5:0] r,
                                             input logic [5:0] c);
      return {bank, r, c};
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/bmte_store.sv =====
// Two-bank cell memory: one write port, two registered read ports.
// Depends on bmte_pkg.
`default_nettype none
module bmte_store (
   input  wire logic                 clock,
   input  wire bmte_pkg::mem_req_type req,
   output logic [7:0]                rd_data_a,
   output logic [7:0]                rd_data_b
);
   import bmte_pkg::*;
   logic [7:0] mem [0:8191];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_a <= mem[req.rd_addr_a];
      rd_data_b <= mem[req.rd_addr_b];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/byte_matrix_transform_engine.sv =====
// Byte matrix transform engine top level: opcode check, loop sequencer
// over cell pairs, and the two-bank store. Depends on bmte_pkg, bmte_store.
// Each swapped pair is read (both cells), waited on, and written back cell by cell;
// rotate reads each cell, waits, and writes it into the other bank.
// One transaction at a time; busy is high from start until the result strobe.
// Synchronous reset clears dims, active bank and sequencer; cells stay undefined.
`default_nettype none
module byte_matrix_transform_engine #(
   parameter int MAX_SIDE = bmte_pkg::DEF_MAX_SIDE
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [3:0] req_op,
   input  wire logic [5:0] req_row_a,
   input  wire logic [5:0] req_col_a,
   input  wire logic [5:0] req_row_b,
   input  wire logic [5:0] req_col_b,
   input  wire logic signed [6:0] req_diagonal,
   input  wire logic [7:0] req_cell_value,
   output logic            rsp_valid,
   output logic [7:0]      rsp_read_value,
   output logic            rsp_ok
);
   import bmte_pkg::*;

   localparam logic [8:0] MAX_SIDE_W = 9'(MAX_SIDE);

   state_type state_ff, state_in;
   op_type    op_ff;
   logic [5:0] rows_ff, cols_ff, rows_in, cols_in;
   logic       bank_ff, bank_in;
   logic [5:0] ra_ff, ca_ff, rb_ff, cb_ff, dabs_ff;
   logic       neg_ff;
   logic [5:0] i_ff, i_in, j_ff, j_in;
   logic [7:0] hold_a_ff, hold_b_ff;
   logic       ok_ff, ok_in, rd_ff, rd_in;
   logic [7:0] rv_ff, rv_in;
   logic       vld_ff, vld_in;
   mem_req_type mreq;
   logic [7:0] rda, rdb;

   // cell pair coordinates of the current loop step
   logic [5:0] r1, c1, r2, c2;
   logic [5:0] ni, nj;         // loop bounds
   logic       last_i, last_j;

   bmte_store u_store (.clock(clock), .req(mreq), .rd_data_a(rda), .rd_data_b(rdb));

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_read_value = rv_ff;
   assign rsp_ok = ok_ff;

   always_comb begin
      r1 = '0; c1 = '0; r2 = '0; c2 = '0; ni = 6'd1; nj = 6'd1;
      case (op_ff)
         OP_SWAP_CELL: begin r1 = ra_ff; c1 = ca_ff; r2 = rb_ff; c2 = cb_ff; end
         OP_SWAP_ROW: begin r1 = ra_ff; c1 = i_ff; r2 = rb_ff; c2 = i_ff; ni = cols_ff; end
         OP_SWAP_COL: begin r1 = i_ff; c1 = ca_ff; r2 = i_ff; c2 = cb_ff; ni = rows_ff; end
         OP_SWAP_DIAG: begin
            r1 = i_ff; c1 = i_ff + dabs_ff; r2 = i_ff + dabs_ff; c2 = i_ff;
            ni = cols_ff - dabs_ff;
         end
         OP_FLIP_ROW: begin
            r1 = ra_ff; c1 = i_ff; r2 = ra_ff; c2 = cols_ff - 6'd1 - i_ff;
            ni = cols_ff >> 1;
         end
         OP_FLIP_COL: begin
            r1 = i_ff; c1 = ca_ff; r2 = rows_ff - 6'd1 - i_ff; c2 = ca_ff;
            ni = rows_ff >> 1;
         end
         OP_FLIP_DIAG: begin
            ni = (cols_ff - dabs_ff) >> 1;
            if (!neg_ff) begin
               r1 = i_ff; c1 = i_ff + dabs_ff;
               r2 = rows_ff - 6'd1 - i_ff - dabs_ff; c2 = cols_ff - 6'd1 - i_ff;
            end else begin
               r1 = i_ff + dabs_ff; c1 = i_ff;
               r2 = rows_ff - 6'd1 - i_ff; c2 = cols_ff - 6'd1 - i_ff - dabs_ff;
            end
         end
         OP_MIRROR_LR: begin
            r1 = j_ff; c1 = i_ff; r2 = j_ff; c2 = cols_ff - 6'd1 - i_ff;
            ni = cols_ff >> 1; nj = rows_ff;
         end
         OP_MIRROR_TB: begin
            r1 = i_ff; c1 = j_ff; r2 = rows_ff - 6'd1 - i_ff; c2 = j_ff;
            ni = rows_ff >> 1; nj = cols_ff;
         end
         OP_ROTATE: begin
            r1 = i_ff; c1 = j_ff; r2 = j_ff; c2 = rows_ff - 6'd1 - i_ff;
            ni = rows_ff; nj = cols_ff;
         end
         OP_TRANSPOSE: begin
            r1 = i_ff; c1 = j_ff; r2 = j_ff; c2 = i_ff;
            ni = rows_ff; nj = cols_ff;
         end
         default: begin end
      endcase
      last_j = (j_ff + 6'd1 >= nj);
      last_i = (i_ff + 6'd1 >= ni);
   end

   // request check and loop entry
   logic [5:0] din_abs;
   logic       req_good, req_empty;
   logic [5:0] first_j;
   always_comb begin
      logic sq, dok;
      din_abs = req_diagonal[6] ? 6'(7'd0 - 7'(req_diagonal)) : req_diagonal[5:0];
      sq = (rows_ff == cols_ff);
      // a magnitude of 64 overflows six bits: reject it outright
      dok = sq && !(req_diagonal == -7'sd64) && (din_abs < cols_ff);
      req_good = 1'b0; req_empty = 1'b0; first_j = '0;
      case (op_type'(req_op))
         OP_SET_DIMS: req_good = ({3'b000, req_row_a} < MAX_SIDE_W) &&
                                 ({3'b000, req_col_a} < MAX_SIDE_W);
         OP_WRITE, OP_READ: req_good = (req_row_a < rows_ff) && (req_col_a < cols_ff);
         OP_SWAP_CELL: req_good = (req_row_a < rows_ff) && (req_col_a < cols_ff) &&
                                  (req_row_b < rows_ff) && (req_col_b < cols_ff);
         OP_SWAP_ROW: begin
            req_good = (req_row_a < rows_ff) && (req_row_b < rows_ff);
            req_empty = (cols_ff == 6'd0);
         end
         OP_SWAP_COL: begin
            req_good = (req_col_a < cols_ff) && (req_col_b < cols_ff);
            req_empty = (rows_ff == 6'd0);
         end
         OP_SWAP_DIAG: req_good = dok;
         OP_FLIP_ROW: begin
            req_good = (req_row_a < rows_ff); req_empty = (cols_ff < 6'd2);
         end
         OP_FLIP_COL: begin
            req_good = (req_col_a < cols_ff); req_empty = (rows_ff < 6'd2);
         end
         OP_FLIP_DIAG: begin
            req_good = dok; req_empty = ((cols_ff - din_abs) < 6'd2);
         end
         OP_MIRROR_LR: begin
            req_good = 1'b1; req_empty = (cols_ff < 6'd2) || (rows_ff == 6'd0);
         end
         OP_MIRROR_TB: begin
            req_good = 1'b1; req_empty = (rows_ff < 6'd2) || (cols_ff == 6'd0);
         end
         OP_ROTATE: begin
            req_good = 1'b1; req_empty = (rows_ff == 6'd0) || (cols_ff == 6'd0);
         end
         OP_TRANSPOSE: begin
            req_good = sq; req_empty = (cols_ff < 6'd2); first_j = 6'd1;
         end
         default: req_good = 1'b0;
      endcase
   end

   always_comb begin
      logic is_rot;
      state_in = state_ff; rows_in = rows_ff; cols_in = cols_ff; bank_in = bank_ff;
      i_in = i_ff; j_in = j_ff; ok_in = ok_ff; rd_in = rd_ff; rv_in = rv_ff;
      vld_in = 1'b0;
      is_rot = (op_ff == OP_ROTATE);
      mreq.wr_en = 1'b0;
      mreq.wr_addr = cell_addr(bank_ff, r1, c1);
      mreq.wr_data = hold_b_ff;
      mreq.rd_addr_a = cell_addr(bank_ff, r1, c1);
      mreq.rd_addr_b = cell_addr(bank_ff, r2, c2);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ok_in = req_good; rd_in = 1'b0; rv_in = '0; i_in = '0; j_in = first_j;
               if (!req_good || req_empty || op_type'(req_op) == OP_SET_DIMS ||
                   op_type'(req_op) == OP_WRITE) begin
                  state_in = ST_DONE;
               end else begin
                  rd_in = (op_type'(req_op) == OP_READ);
                  state_in = ST_RD;
               end
               if (req_good && op_type'(req_op) == OP_SET_DIMS) begin
                  rows_in = req_row_a; cols_in = req_col_a;
               end
               if (req_good && op_type'(req_op) == OP_WRITE) begin
                  mreq.wr_en = 1'b1;
                  mreq.wr_addr = cell_addr(bank_ff, req_row_a, req_col_a);
                  mreq.wr_data = req_cell_value;
               end
               if (req_good && req_empty && op_type'(req_op) == OP_ROTATE) begin
                  bank_in = ~bank_ff; rows_in = cols_ff; cols_in = rows_ff;
               end
            end
         end
         ST_RD: begin
            mreq.rd_addr_a = rd_ff ? cell_addr(bank_ff, ra_ff, ca_ff)
                                   : cell_addr(bank_ff, r1, c1);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (rd_ff) begin
               rv_in = rda; state_in = ST_DONE;
            end else begin
               state_in = ST_WR_A;
            end
         end
         ST_WR_A: begin
            mreq.wr_en = 1'b1;
            if (is_rot) begin
               mreq.wr_addr = cell_addr(~bank_ff, r2, c2);
               mreq.wr_data = hold_a_ff;
            end else begin
               mreq.wr_addr = cell_addr(bank_ff, r1, c1);
               mreq.wr_data = hold_b_ff;
            end
            state_in = is_rot ? ST_RD : ST_WR_B;
            if (is_rot) begin
               // advance the loop; finish after the last cell
               if (last_j) begin
                  j_in = '0; i_in = i_ff + 6'd1;
                  if (last_i) begin
                     state_in = ST_DONE;
                     bank_in = ~bank_ff; rows_in = cols_ff; cols_in = rows_ff;
                  end
               end else begin
                  j_in = j_ff + 6'd1;
               end
            end
         end
         ST_WR_B: begin
            mreq.wr_en = 1'b1;
            mreq.wr_addr = cell_addr(bank_ff, r2, c2);
            mreq.wr_data = hold_a_ff;
            state_in = ST_RD;
            if (op_ff == OP_TRANSPOSE) begin
               // j runs from i+1 to one below the column count
               if (j_ff + 6'd1 >= cols_ff) begin
                  i_in = i_ff + 6'd1; j_in = i_ff + 6'd2;
                  if (i_ff + 6'd2 >= cols_ff) state_in = ST_DONE;
               end else begin
                  j_in = j_ff + 6'd1;
               end
            end else if (last_j) begin
               j_in = '0; i_in = i_ff + 6'd1;
               if (last_i) state_in = ST_DONE;
            end else begin
               j_in = j_ff + 6'd1;
            end
         end
         ST_DONE: begin
            vld_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rows_ff <= '0; cols_ff <= '0; bank_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rows_ff <= rows_in; cols_ff <= cols_in;
         bank_ff <= bank_in; vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; ok_ff <= ok_in; rd_ff <= rd_in; rv_ff <= rv_in;
      if (state_ff == ST_IDLE && start) begin
         op_ff <= op_type'(req_op); ra_ff <= req_row_a; ca_ff <= req_col_a;
         rb_ff <= req_row_b; cb_ff <= req_col_b; dabs_ff <= din_abs;
         neg_ff <= req_diagonal[6];
      end
      if (state_ff == ST_WAIT) begin
         hold_a_ff <= rda; hold_b_ff <= rdb;
      end
   end

`ifndef SYNTH
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> !busy) else $error("busy during result strobe");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      vld_ff |=> !vld_ff) else $error("double result strobe");
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !ok_ff) |-> (rv_ff == 8'd0)) else $error("rejected with data");
   a_dims: assert property (@(posedge clock) disable iff (reset)
      ({3'b000, rows_ff} < MAX_SIDE_W))
      else $error("row count out of range");
`endif
endmodule
`default_nettype wire
